// ----- rtl/kwm_pkg.sv -----
// Package for the k-way merge selector: default sizes, field widths,
// result status codes and the sequencer state type.
// No dependencies.
package kwm_pkg;

  // Default sizes
  localparam int unsigned KWM_NUM_LISTS  = 8;
  localparam int unsigned KWM_LIST_DEPTH = 256;

  // Field widths
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;

  // Request modes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_PUSHED  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_DROPPED = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_POPPED  = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_DRAIN,
    S_POP
  } kwm_state_e;

endpackage

// ----- rtl/kwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kwm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/k_way_merge_selector.sv -----
// K-way merge selector over NUM_LISTS FIFOs held in one shared RAM.
// Depends on kwm_pkg and kwm_ram.
//
// Usage:
//   A request is taken at a rising edge where start_i is high and busy_o is
//   low. mode_i = 0 pushes value_i onto list list_index_i; mode_i = 1 pops the
//   smallest head value over all non-empty lists (lowest index wins a tie).
//   Each request yields exactly one result, shown for one cycle with done_o
//   high: out_value_o, source_list_o and status_o (0 pushed, 1 dropped because
//   the list is full or does not exist, 2 popped, 3 all lists empty).
//   A push passes through the S_PUSH state before done_o; a pop passes through
//   S_SCAN, S_DRAIN and S_POP. The pop scans one list head per cycle through
//   the single RAM read port, and one signed comparator weighs each head
//   against the best so far; the registered RAM read needs the S_DRAIN state,
//   and S_POP updates the head and count.
//   busy_o is low again in the cycle done_o is high, so the next request can
//   be taken then. Results cannot be held off: done_o is a one-cycle strobe.
//   Reset clears all head pointers and entry counts, so every list is empty;
//   the value RAM is not cleared and no clearing pass is needed.
module k_way_merge_selector
  import kwm_pkg::*;
#(
  parameter int unsigned NUM_LISTS  = KWM_NUM_LISTS,
  parameter int unsigned LIST_DEPTH = KWM_LIST_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     mode_i,
  input  logic [IDX_W-1:0]         list_index_i,
  input  logic signed [VAL_W-1:0]  value_i,
  output logic                     done_o,
  output logic signed [VAL_W-1:0]  out_value_o,
  output logic [IDX_W-1:0]         source_list_o,
  output logic [STAT_W-1:0]        status_o
);

  localparam int unsigned LW = $clog2(NUM_LISTS);
  localparam int unsigned HW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = $clog2(NUM_LISTS * LIST_DEPTH);

  kwm_state_e state_q, state_d;

  // Request and scan registers
  logic [IDX_W-1:0]        idx_q;
  logic signed [VAL_W-1:0] value_q;
  logic [LW-1:0]           scan_q, scan_d;
  logic                    pend_q, pend_d;
  logic [LW-1:0]           pend_lst_q, pend_lst_d;
  logic                    found_q, found_d;
  logic [LW-1:0]           best_q, best_d;
  logic signed [VAL_W-1:0] best_val_q, best_val_d;

  // Result registers
  logic                    done_q, done_d;
  logic signed [VAL_W-1:0] res_val_q, res_val_d;
  logic [IDX_W-1:0]        res_src_q, res_src_d;
  logic [STAT_W-1:0]       res_stat_q, res_stat_d;

  // Per-list FIFO pointers
  logic [HW-1:0] head_q [NUM_LISTS];
  logic [CW-1:0] cnt_q  [NUM_LISTS];

  logic [LW-1:0]   lst_sel;
  logic [HW-1:0]   head_rd;
  logic [CW-1:0]   cnt_rd;
  logic [HW:0]     tail_sum;
  logic [HW-1:0]   tail_slot;
  logic [HW-1:0]   head_next;
  logic            push_ok;
  logic            take;
  logic            cnt_inc, cnt_dec;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  // Pointer read port, addressed by the list under work
  assign head_rd = head_q[lst_sel];
  assign cnt_rd  = cnt_q[lst_sel];

  // Tail slot and next head, both wrapped modulo the list depth
  assign tail_sum  = (HW+1)'(head_rd) + (HW+1)'(cnt_rd);
  assign tail_slot = (tail_sum >= (HW+1)'(LIST_DEPTH)) ?
                     HW'(tail_sum - (HW+1)'(LIST_DEPTH)) : HW'(tail_sum);
  assign head_next = (head_rd == HW'(LIST_DEPTH - 1)) ? '0 : head_rd + HW'(1);

  assign push_ok = (32'(idx_q) < NUM_LISTS) && (cnt_rd != CW'(LIST_DEPTH));

  // Shared comparator: pending head against best so far
  assign take = pend_q && (!found_q || ($signed(mem_rdata) < best_val_q));

  assign mem_waddr = AW'(lst_sel) * AW'(LIST_DEPTH) + AW'(tail_slot);
  assign mem_raddr = AW'(lst_sel) * AW'(LIST_DEPTH) + AW'(head_rd);

  kwm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NUM_LISTS * LIST_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (value_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = (mode_i == MODE_POP) ? S_SCAN : S_PUSH;
        end
      end
      S_PUSH:  state_d = S_IDLE;
      S_SCAN: begin
        if (scan_q == LW'(NUM_LISTS - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_POP;
      S_POP:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control and result formation
  always_comb begin
    lst_sel    = scan_q;
    scan_d     = scan_q;
    pend_d     = 1'b0;
    pend_lst_d = scan_q;
    found_d    = found_q;
    best_d     = best_q;
    best_val_d = best_val_q;
    done_d     = 1'b0;
    res_val_d  = res_val_q;
    res_src_d  = res_src_q;
    res_stat_d = res_stat_q;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        scan_d  = '0;
        found_d = 1'b0;
      end
      S_PUSH: begin
        lst_sel   = LW'(idx_q);
        done_d    = 1'b1;
        res_val_d = '0;
        res_src_d = '0;
        if (push_ok) begin
          mem_we     = 1'b1;
          cnt_inc    = 1'b1;
          res_stat_d = STATUS_PUSHED;
        end else begin
          res_stat_d = STATUS_DROPPED;
        end
      end
      S_SCAN: begin
        // Issue the head read for this list, weigh the one read last cycle
        mem_re     = (cnt_rd != '0);
        pend_d     = (cnt_rd != '0);
        pend_lst_d = scan_q;
        scan_d     = scan_q + LW'(1);
        if (take) begin
          found_d    = 1'b1;
          best_d     = pend_lst_q;
          best_val_d = $signed(mem_rdata);
        end
      end
      S_DRAIN: begin
        if (take) begin
          found_d    = 1'b1;
          best_d     = pend_lst_q;
          best_val_d = $signed(mem_rdata);
        end
      end
      S_POP: begin
        lst_sel = best_q;
        done_d  = 1'b1;
        if (found_q) begin
          cnt_dec    = 1'b1;
          res_val_d  = best_val_q;
          res_src_d  = IDX_W'(best_q);
          res_stat_d = STATUS_POPPED;
        end else begin
          res_val_d  = '0;
          res_src_d  = '0;
          res_stat_d = STATUS_EMPTY;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      idx_q   <= list_index_i;
      value_q <= value_i;
    end
    pend_lst_q <= pend_lst_d;
    best_q     <= best_d;
    best_val_q <= best_val_d;
    res_val_q  <= res_val_d;
    res_src_q  <= res_src_d;
    res_stat_q <= res_stat_d;
  end

  // Head pointers and entry counts: heads advance and counts shrink on pop, counts grow on push
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (cnt_inc) begin
      cnt_q[lst_sel] <= cnt_rd + CW'(1);
    end else if (cnt_dec) begin
      cnt_q[lst_sel]  <= cnt_rd - CW'(1);
      head_q[lst_sel] <= head_next;
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign out_value_o   = res_val_q;
  assign source_list_o = res_src_q;
  assign status_o      = res_stat_q;

endmodule

// ----- rtl/kwm_checker.sv -----
// Port-level checker for the k-way merge selector, bound to the top level.
// Depends on kwm_pkg.
module kwm_checker
  import kwm_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic                    mode_i,
  input logic                    done_o,
  input logic signed [VAL_W-1:0] out_value_o,
  input logic [IDX_W-1:0]        source_list_o,
  input logic [STAT_W-1:0]       status_o
);

  // A result strobe comes only when the block is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done_o while busy_o is high");

  // A taken push request passes through S_PUSH and ends in a pushed or dropped result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_PUSH) |-> ##2
      (done_o && (status_o == STATUS_PUSHED || status_o == STATUS_DROPPED)))
    else $error("push request did not complete as a push result");

  // A pop request keeps the block busy and gives no immediate result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_POP) |=> (busy_o && !done_o))
    else $error("pop request not held busy");

  // Only a popped result carries a value and a source list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_POPPED) |-> (out_value_o == '0 && source_list_o == '0))
    else $error("non-pop result carries a value");

  // One request, one strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

bind k_way_merge_selector kwm_checker u_kwm_checker (.*);

// ----- sim/k_way_merge_selector_tb.sv -----
// Self-checking testbench for k_way_merge_selector: directed and random
// push/pop requests checked against an in-bench merge predictor.
// Depends on kwm_pkg and the k_way_merge_selector RTL.
`timescale 1ns / 100ps

module k_way_merge_selector_tb;
  import kwm_pkg::*;

  localparam int unsigned LISTS       = KWM_NUM_LISTS;
  localparam int unsigned DEPTH       = KWM_LIST_DEPTH;
  localparam int unsigned RANDOM_REQS = 100;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        src;
    logic [STAT_W-1:0]       status;
  } merge_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic                    mode_i;
  logic [IDX_W-1:0]        list_index_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    done_o;
  logic signed [VAL_W-1:0] out_value_o;
  logic [IDX_W-1:0]        source_list_o;
  logic [STAT_W-1:0]       status_o;

  // Predictor copy of the list state
  logic signed [VAL_W-1:0] lane_mem [LISTS][DEPTH];
  logic [7:0]              lane_head [LISTS] = '{default: '0};
  logic [8:0]              lane_fill [LISTS] = '{default: '0};

  merge_result_t pending_results [$];
  int unsigned   requests_sent = 0;
  int unsigned   mismatches    = 0;
  int unsigned   cycle_count   = 0;
  int unsigned   n_pushed      = 0;
  int unsigned   n_dropped     = 0;
  int unsigned   n_popped      = 0;
  int unsigned   n_empty       = 0;
  bit            gaps_on       = 1'b1;

  k_way_merge_selector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .list_index_i  (list_index_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .out_value_o   (out_value_o),
    .source_list_o (source_list_o),
    .status_o      (status_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Apply one request to the predicted list state and return its result
  function automatic merge_result_t merge_predict(input logic mode,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic signed [VAL_W-1:0] val);
    merge_result_t           res;
    logic signed [VAL_W-1:0] best_val;
    logic signed [VAL_W-1:0] head_val;
    int unsigned             best;
    bit                      found;
    logic [7:0]              tail;
    res      = '{value: '0, src: '0, status: STATUS_PUSHED};
    best_val = '0;
    best     = 0;
    found    = 1'b0;
    if (mode == MODE_PUSH) begin
      if (idx >= LISTS || lane_fill[idx] >= DEPTH) begin
        res.status = STATUS_DROPPED;
      end else begin
        tail = lane_head[idx] + lane_fill[idx][7:0];
        lane_mem[idx][tail] = val;
        lane_fill[idx]++;
      end
    end else begin
      // Scan heads in index order; strict less-than keeps the lowest index on a tie
      for (int i = 0; i < LISTS; i++) begin
        if (lane_fill[i] != 0) begin
          head_val = lane_mem[i][lane_head[i]];
          if (!found || head_val < best_val) begin
            found    = 1'b1;
            best     = i;
            best_val = head_val;
          end
        end
      end
      if (!found) begin
        res.status = STATUS_EMPTY;
      end else begin
        lane_head[best]++;
        lane_fill[best]--;
        res.value  = best_val;
        res.src    = best[IDX_W-1:0];
        res.status = STATUS_POPPED;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
    mismatches++;
    $display("cycle %0d: %s mismatch, expected 0x%08h got 0x%08h", cycle_count, what,
             want, got);
  endtask

  // Hold the request until it is taken, then record its expected result
  task automatic send_request(input logic mode, input logic [IDX_W-1:0] idx,
                              input logic signed [VAL_W-1:0] val);
    start_i      <= 1'b1;
    mode_i       <= mode;
    list_index_i <= idx;
    value_i      <= val;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(merge_predict(mode, idx, val));
    requests_sent++;
    if (gaps_on && $urandom_range(0, 99) < 25) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic push_value(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] val);
    send_request(MODE_PUSH, idx, val);
  endtask

  // Pop with random content in the ignored fields
  task automatic pop_head();
    send_request(MODE_POP, IDX_W'($urandom), $urandom);
  endtask

  function automatic int pick_value();
    int small_val;
    small_val = $urandom_range(0, 8);
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return small_val - 4;
      default: return $urandom;
    endcase
  endfunction

  // Check each result strobe against the oldest expectation
  always @(posedge clk_i) begin : check_result
    merge_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result status", '0, VAL_W'(status_o));
      end else begin
        want = pending_results.pop_front();
        if (out_value_o !== want.value)
          report_mismatch("out_value", want.value, out_value_o);
        if (source_list_o !== want.src)
          report_mismatch("source_list", VAL_W'(want.src), VAL_W'(source_list_o));
        if (status_o !== want.status)
          report_mismatch("status", VAL_W'(want.status), VAL_W'(status_o));
        case (want.status)
          STATUS_PUSHED:  n_pushed++;
          STATUS_DROPPED: n_dropped++;
          STATUS_POPPED:  n_popped++;
          default:        n_empty++;
        endcase
      end
    end
  end

  // Extreme values, every list, ties across lists and pops on empty lists
  task automatic test_extremes();
    pop_head();
    push_value(0, 32'sh7fff_ffff);
    push_value(1, 32'sh8000_0000);
    push_value(2, -1);
    push_value(3, 0);
    push_value(4, 1);
    push_value(5, -1);
    push_value(6, 32'sh8000_0000);
    push_value(7, 32'sh5555_5555);
    push_value(7, 32'shAAAA_AAAA);
    repeat (10) pop_head();
    pop_head();
  endtask

  // Fill one list past its depth across the pointer wrap, then drain everything
  task automatic test_full_list();
    for (int i = 0; i < DEPTH; i++) push_value(6, $urandom);
    push_value(6, 32'sh7fff_ffff);
    push_value(6, 32'sh8000_0000);
    push_value(2, 32'sh0000_1234);
    repeat (DEPTH + 2) pop_head();
  endtask

  // Mostly sorted runs merged back out; the rest unsorted noise
  task automatic test_random_merge();
    int          run_vals [$];
    int unsigned first_req;
    int unsigned run_total;
    first_req = requests_sent;
    while (requests_sent - first_req < RANDOM_REQS) begin
      // Hold a stretch with no gaps between requests
      gaps_on = !((requests_sent - first_req) inside {[10:70]});
      if ($urandom_range(0, 9) < 7) begin
        run_total = 0;
        repeat ($urandom_range(2, 8)) begin
          run_vals.delete();
          repeat ($urandom_range(1, 6)) run_vals.push_back(pick_value());
          run_vals.sort();
          foreach (run_vals[k]) push_value(IDX_W'($urandom), run_vals[k]);
          run_total += run_vals.size();
        end
        repeat (run_total + $urandom_range(0, 1)) pop_head();
      end else begin
        repeat ($urandom_range(5, 15)) begin
          if ($urandom_range(0, 1)) pop_head();
          else push_value(IDX_W'($urandom), pick_value());
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    start_i      = 1'b0;
    mode_i       = MODE_PUSH;
    list_index_i = '0;
    value_i      = '0;
    rst_ni       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_full_list();
    test_random_merge();

    // Drop start and let the last results come back
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("%0d requests: %0d pushed, %0d dropped, %0d popped, %0d empty pops",
             requests_sent, n_pushed, n_dropped, n_popped, n_empty);
    $display("%0d mismatches over %0d cycles", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/kwm_pkg.sv
rtl/kwm_ram.sv
rtl/k_way_merge_selector.sv
rtl/kwm_checker.sv
sim/k_way_merge_selector_tb.sv
